@@ design/rrs_pkg.sv @@
// Shared types, constants and the remote duty-to-interval table for the
// rate setpoint ramp. No dependencies.
package rrs_pkg;

    localparam logic [31:0] FROZEN        = 32'hFFFF_FFFF;
    localparam logic [31:0] PERIOD_RESET  = 32'd20000;
    localparam logic [6:0]  DUTY_MIN      = 7'd38;
    localparam logic [6:0]  DUTY_MID      = 7'd50;
    localparam logic [6:0]  DUTY_MAX      = 7'd62;
    localparam int          NUM_DIRS      = 4;

    // one classified word handed from front to back
    typedef struct packed {
        logic [31:0] now_us;
        logic [31:0] cw_remote;
        logic [31:0] ccw_remote;
        logic [31:0] cw_app;
        logic [31:0] ccw_app;
    } work_t;

    // 10000 + k * 30000 / 11, truncated; k = 0 is the fast end
    function automatic logic [31:0] remote_interval(input logic [3:0] k);
        logic [15:0] iv;
        begin
            case (k)
                4'd0:    iv = 16'd10000;
                4'd1:    iv = 16'd12727;
                4'd2:    iv = 16'd15454;
                4'd3:    iv = 16'd18181;
                4'd4:    iv = 16'd20909;
                4'd5:    iv = 16'd23636;
                4'd6:    iv = 16'd26363;
                4'd7:    iv = 16'd29090;
                4'd8:    iv = 16'd31818;
                4'd9:    iv = 16'd34545;
                4'd10:   iv = 16'd37272;
                4'd11:   iv = 16'd40000;
                default: iv = 16'd40000;
            endcase
            return {16'd0, iv};
        end
    endfunction

endpackage

@@ design/rrs_ifs.sv @@
// Handshake channels of the rate setpoint ramp: input items, results and
// the configuration write channel. No dependencies.
interface rrs_item_if;
    logic               valid;
    logic               ready;
    logic        [31:0] now_us;
    logic               remote_enable_n;
    logic        [6:0]  duty_cycle;
    logic signed [31:0] app_rate;

    modport source (output valid, now_us, remote_enable_n, duty_cycle, app_rate,
                    input ready);
    modport sink   (input valid, now_us, remote_enable_n, duty_cycle, app_rate,
                    output ready);
endinterface

interface rrs_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint;

    modport source (output valid, setpoint, input ready);
    modport sink   (input valid, setpoint, output ready);
endinterface

interface rrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/rrs_front.sv @@
// Front end: accepts items, samples the remote and resolves the four
// direction intervals. Depends on rrs_pkg and rrs_ifs.
module rrs_front (
    input  logic           clk,
    input  logic           rst_n,
    rrs_item_if.sink       item,
    rrs_cfg_if.sink        cfg,
    input  logic           push_ready,
    output logic           push_valid,
    output rrs_pkg::work_t push_data
);
    import rrs_pkg::*;

    logic [31:0] remote_period_reg;
    logic [31:0] last_sample_reg, last_sample_next;
    logic [31:0] cw_remote_reg, cw_remote_next;
    logic [31:0] ccw_remote_reg, ccw_remote_next;
    logic [31:0] sample_elapsed;
    logic        sample_due;
    logic        accept;
    logic [6:0]  duty;
    logic [6:0]  cw_idx, ccw_idx;
    logic [31:0] app_bits;

    assign item.ready = push_ready;
    assign accept     = item.valid && push_ready;
    assign cfg.ready  = 1'b1;

    assign sample_elapsed = item.now_us - last_sample_reg;
    assign sample_due     = sample_elapsed >= remote_period_reg;

    always_comb
    begin
        duty = item.duty_cycle;
        if (duty < DUTY_MIN)
            duty = DUTY_MIN;
        if (duty > DUTY_MAX)
            duty = DUTY_MAX;
        cw_idx  = DUTY_MAX - duty;
        ccw_idx = duty - DUTY_MIN;

        last_sample_next = last_sample_reg;
        cw_remote_next   = cw_remote_reg;
        ccw_remote_next  = ccw_remote_reg;
        if (sample_due)
        begin
            last_sample_next = item.now_us;
            cw_remote_next   = FROZEN;
            ccw_remote_next  = FROZEN;
            if (!item.remote_enable_n)
            begin
                if (duty > DUTY_MID)
                    cw_remote_next = remote_interval(cw_idx[3:0]);
                else if (duty < DUTY_MID)
                    ccw_remote_next = remote_interval(ccw_idx[3:0]);
            end
        end
    end

    assign app_bits = item.app_rate;

    always_comb
    begin
        push_valid           = accept;
        push_data.now_us     = item.now_us;
        push_data.cw_remote  = cw_remote_next;
        push_data.ccw_remote = ccw_remote_next;
        if (app_bits[31])
        begin
            push_data.cw_app  = FROZEN;
            push_data.ccw_app = 32'd0 - app_bits;
        end
        else
        begin
            push_data.cw_app  = app_bits;
            push_data.ccw_app = FROZEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_period_reg <= PERIOD_RESET;
            last_sample_reg   <= 32'd0;
            cw_remote_reg     <= FROZEN;
            ccw_remote_reg    <= FROZEN;
        end
        else
        begin
            if (cfg.valid)
                remote_period_reg <= cfg.data;
            if (accept)
            begin
                last_sample_reg <= last_sample_next;
                cw_remote_reg   <= cw_remote_next;
                ccw_remote_reg  <= ccw_remote_next;
            end
        end
    end

endmodule

@@ design/rrs_queue.sv @@
// Two-entry queue between front and back end. Depends on rrs_pkg.
module rrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rrs_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rrs_pkg::work_t pop_data
);
    import rrs_pkg::*;

    work_t       entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

endmodule

@@ design/rrs_back.sv @@
// Back end: checks the four direction intervals against the step time and
// holds the setpoint, which doubles as the result register.
// Depends on rrs_pkg and rrs_ifs.
module rrs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  rrs_pkg::work_t pop_data,
    rrs_result_if.source   result
);
    import rrs_pkg::*;

    logic [31:0] last_step_reg, last_step_next;
    logic [15:0] setpoint_reg, setpoint_next;
    logic        out_valid_reg;
    logic [31:0] elapsed;
    logic [31:0] iv [NUM_DIRS];
    logic [NUM_DIRS-1:0] fire;
    logic [1:0]  ups, downs;
    logic        take;

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    assign result.valid    = out_valid_reg;
    assign result.setpoint = setpoint_reg;

    assign elapsed = pop_data.now_us - last_step_reg;
    assign iv[0]   = pop_data.cw_remote;
    assign iv[1]   = pop_data.ccw_remote;
    assign iv[2]   = pop_data.cw_app;
    assign iv[3]   = pop_data.ccw_app;

    // once one direction fires the step time is now, so later ones need zero
    always_comb
    begin
        logic prior;
        prior = 1'b0;
        for (int i = 0; i < NUM_DIRS; i++)
        begin
            if (prior)
                fire[i] = iv[i] == 32'd0;
            else
                fire[i] = (iv[i] != FROZEN) && (elapsed >= iv[i]);
            prior = prior || fire[i];
        end
    end

    // directions 0 and 2 are clockwise (up), 1 and 3 counter-clockwise
    assign ups   = {1'b0, fire[0]} + {1'b0, fire[2]};
    assign downs = {1'b0, fire[1]} + {1'b0, fire[3]};

    assign setpoint_next  = setpoint_reg + {14'd0, ups} - {14'd0, downs};
    assign last_step_next = (|fire) ? pop_data.now_us : last_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_step_reg <= 32'd0;
            setpoint_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                last_step_reg <= last_step_next;
                setpoint_reg  <= setpoint_next;
            end
            if (pop_ready)
                out_valid_reg <= pop_valid;
        end
    end

endmodule

@@ design/rc_rate_setpoint_ramp.sv @@
// Rate setpoint ramp: one item in, one setpoint word out, one item per clock
// sustained while the result receiver is ready. The front end takes an item
// in the cycle it is offered whenever its two-entry queue has room, resolving
// remote and app intervals; the back end runs the four interval checks
// combinationally on the queue head and registers the new setpoint, which
// drives the result channel. The single back-end check unit sets the rate. A
// remote_period write through cfg is always taken; write it only while idle.
// Depends on rrs_pkg, rrs_ifs, rrs_front, rrs_queue, rrs_back.
module rc_rate_setpoint_ramp (
    input  logic         clk,
    input  logic         rst_n,
    rrs_item_if.sink     item,
    rrs_result_if.source result,
    rrs_cfg_if.sink      cfg
);
    import rrs_pkg::*;

    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    work_t push_data, pop_data;

    rrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    rrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

@@ dv/rc_rate_setpoint_ramp_test.sv @@
// Self-checking test of rc_rate_setpoint_ramp: directed and random items with a
// per-item setpoint predictor and an in-order scoreboard of setpoint words.
// Depends on rrs_pkg, rrs_ifs and the ramp RTL.
module rc_rate_setpoint_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV_FROZEN      = 32'hFFFF_FFFF;
    localparam logic [31:0] PERIOD_DEFAULT = 32'd20000;
    localparam logic [31:0] DUTY_FLOOR     = 32'd38;
    localparam logic [31:0] DUTY_CENTRE    = 32'd50;
    localparam logic [31:0] DUTY_CEIL      = 32'd62;
    localparam logic [31:0] IV_FAST        = 32'd10000;
    localparam logic [31:0] IV_SPAN        = 32'd30000;
    localparam logic [31:0] DUTY_STEPS     = 32'd11;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          HOLD_CYCLES    = 300;

    logic clk;
    logic rst_n;

    rrs_item_if   item_ch ();
    rrs_result_if result_ch ();
    rrs_cfg_if    cfg_ch ();

    rc_rate_setpoint_ramp u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    logic [31:0] period_r;
    logic [31:0] sample_t;
    logic [31:0] step_t;
    logic [31:0] cw_rem;
    logic [31:0] ccw_rem;
    logic [31:0] cw_app;
    logic [31:0] ccw_app;
    logic [15:0] sp_r;

    logic [15:0] setpoint_q[$];
    logic [15:0] next_sp;
    logic [15:0] want_sp;

    int          errors;
    int          words_checked;
    int          settings_used;
    int          cycles;
    int          idle_pct;
    int          stall_pct;
    logic        ready_hold;
    logic [31:0] clock_us;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, or a forced hold-off
    always @(posedge clk)
    begin
        if (ready_hold)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic fire_if_due(input logic [31:0] now, input logic [31:0] iv, input bit up);
        logic [31:0] since;
        since = now - step_t;
        if (iv != IV_FROZEN && since >= iv)
        begin
            step_t = now;
            sp_r = up ? sp_r + 16'd1 : sp_r - 16'd1;
        end
    endtask

    task automatic ramp_advance(input logic [31:0] now, input logic en_n,
                                input logic [6:0] duty_in, input logic [31:0] rate,
                                output logic [15:0] sp);
        logic [31:0] since;
        logic [31:0] d;
        since = now - sample_t;
        if (since >= period_r)
        begin
            sample_t = now;
            cw_rem = IV_FROZEN;
            ccw_rem = IV_FROZEN;
            if (!en_n)
            begin
                d = {25'd0, duty_in};
                if (d < DUTY_FLOOR)
                    d = DUTY_FLOOR;
                if (d > DUTY_CEIL)
                    d = DUTY_CEIL;
                if (d > DUTY_CENTRE)
                    cw_rem = IV_FAST + (DUTY_CEIL - d) * IV_SPAN / DUTY_STEPS;
                else if (d < DUTY_CENTRE)
                    ccw_rem = IV_FAST + (d - DUTY_FLOOR) * IV_SPAN / DUTY_STEPS;
            end
        end
        if (rate[31])
        begin
            ccw_app = 32'd0 - rate;
            cw_app = IV_FROZEN;
        end
        else
        begin
            ccw_app = IV_FROZEN;
            cw_app = rate;
        end
        fire_if_due(now, cw_rem, 1'b1);
        fire_if_due(now, ccw_rem, 1'b0);
        fire_if_due(now, cw_app, 1'b1);
        fire_if_due(now, ccw_app, 1'b0);
        sp = sp_r;
    endtask

    // predict on accepted items, check accepted setpoint words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_r = PERIOD_DEFAULT;
            sample_t = 32'd0;
            step_t   = 32'd0;
            cw_rem   = IV_FROZEN;
            ccw_rem  = IV_FROZEN;
            cw_app   = IV_FROZEN;
            ccw_app  = IV_FROZEN;
            sp_r     = 16'd0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                period_r = cfg_ch.data;
            if (item_ch.valid && item_ch.ready)
            begin
                ramp_advance(item_ch.now_us, item_ch.remote_enable_n, item_ch.duty_cycle,
                             item_ch.app_rate, next_sp);
                setpoint_q.push_back(next_sp);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (setpoint_q.size() == 0)
                begin
                    $error("setpoint: expected none, actual %0d", $signed(result_ch.setpoint));
                    errors++;
                end
                else
                begin
                    want_sp = setpoint_q.pop_front();
                    words_checked++;
                    if (result_ch.setpoint !== want_sp)
                    begin
                        $error("setpoint: expected %0d, actual %0d",
                               $signed(want_sp), $signed(result_ch.setpoint));
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [31:0] now, input logic en_n,
                             input logic [6:0] duty, input logic [31:0] rate);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        item_ch.valid           <= 1'b1;
        item_ch.now_us          <= now;
        item_ch.remote_enable_n <= en_n;
        item_ch.duty_cycle      <= duty;
        item_ch.app_rate        <= rate;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // wait until every expected word is back, then let the pipeline settle;
    // the queue is looked at mid-cycle so the last accepted item is counted
    task automatic drain_ramp();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (setpoint_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct <= 0;
        write_period(PERIOD_DEFAULT);
        send_item(32'd1, 1'b1, 7'd50, -32'sd1);          // step down through zero
        send_item(32'd2, 1'b0, 7'd62, 32'd0);            // zero app rate
        send_item(32'd20000, 1'b0, 7'd62, 32'd0);        // fastest clockwise remote
        send_item(32'd40000, 1'b0, 7'd51, 32'd5000);
        send_item(32'd60000, 1'b0, 7'd50, -32'sd3000);   // remote centre
        send_item(32'd80000, 1'b0, 7'd49, -32'sd2);
        send_item(32'd100000, 1'b0, 7'd38, 32'h8000_0000);
        send_item(32'd120000, 1'b0, 7'd0, 32'h7FFF_FFFF);
        send_item(32'd140000, 1'b0, 7'd100, 32'd100);
        send_item(32'd160000, 1'b1, 7'd62, -32'sd7);     // remote disabled
        send_item(32'd180000, 1'b0, 7'd56, 32'd0);
        send_item(32'd180000, 1'b0, 7'd56, 32'd0);       // same time, interval zero
        send_item(32'd200000, 1'b0, 7'd44, -32'sd15000);
        send_item(32'hFFFF_F000, 1'b0, 7'd60, 32'd12345);
        send_item(32'h0000_1000, 1'b0, 7'd40, -32'sd12345); // elapsed wraps
        send_item(32'hFFFF_FFFF, 1'b1, 7'd99, 32'd1);
        drain_ramp();
        write_period(32'd0);                             // sampled on every word
        send_item(32'd5, 1'b0, 7'd37, 32'd0);
        send_item(32'd5, 1'b0, 7'd63, -32'sd1);
        send_item(32'd6, 1'b1, 7'd50, 32'd3);
        send_item(32'd50006, 1'b0, 7'd70, -32'sd9);
        send_item(32'd90006, 1'b0, 7'd20, 32'd40000);
        drain_ramp();
    endtask

    task automatic random_word(output logic en_n, output logic [6:0] duty,
                               output logic [31:0] rate);
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            clock_us = $urandom;
        else if (pick < 25)
            clock_us = clock_us + $urandom_range(0, 200);
        else
            clock_us = clock_us + $urandom_range(0, 20000);
        en_n = ($urandom_range(99) < 20);
        duty = ($urandom_range(99) < 70) ? 7'($urandom_range(36, 64))
                                         : 7'($urandom_range(0, 100));
        pick = $urandom_range(99);
        if (pick < 15)
            rate = 32'($signed($urandom_range(0, 2)) - 1);
        else if (pick < 80)
            rate = ($urandom_range(1)) ? 32'($urandom_range(0, 50000))
                                       : 32'd0 - 32'($urandom_range(1, 50000));
        else
            rate = $urandom;
    endtask

    task automatic test_random(input int count, input logic [31:0] period,
                               input int idle, input int stall);
        logic        en_n;
        logic [6:0]  duty;
        logic [31:0] rate;
        idle_pct = idle;
        stall_pct <= stall;
        write_period(period);
        for (int i = 0; i < count; i++)
        begin
            random_word(en_n, duty, rate);
            send_item(clock_us, en_n, duty, rate);
        end
        drain_ramp();
    endtask

    // receiver blocked for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        logic        en_n;
        logic [6:0]  duty;
        logic [31:0] rate;
        idle_pct = 0;
        stall_pct <= 0;
        write_period(32'd15000);
        fork
            begin
                ready_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                ready_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
        begin
            random_word(en_n, duty, rate);
            send_item(clock_us, en_n, duty, rate);
        end
        drain_ramp();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        words_checked = 0;
        settings_used = 0;
        idle_pct = 0;
        stall_pct = 0;
        ready_hold = 1'b0;
        clock_us = 32'd0;
        item_ch.valid = 1'b0;
        item_ch.now_us = 32'd0;
        item_ch.remote_enable_n = 1'b1;
        item_ch.duty_cycle = 7'd0;
        item_ch.app_rate = 32'sd0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        clock_us = $urandom;
        test_random(200, PERIOD_DEFAULT, 0, 0);
        test_random(200, 32'd1, 77, 0);
        test_random(200, IV_FROZEN, 0, 77);
        test_random(200, 32'($urandom_range(100, 60000)), 23, 23);
        clock_us = 32'hFFF0_0000;
        test_random(200, 32'($urandom_range(1000, 30000)), 77, 0);
        test_random(200, 32'd0 - 32'd2, 0, 77);
        test_backpressure();

        repeat (10) @(posedge clk);
        $display("Checked %0d setpoint words over %0d remote_period writes,",
                 words_checked, settings_used);
        $display("with sender gaps, receiver stalls and one long receiver hold-off.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
